@@ hw/rtl/slr_pkg.sv @@
// ---------------------------------------------------------------------------
// slr_pkg: shared types and constants for the string literal recognizer
// Scan modes, verdict codes, character codes and the byte class helpers.
// ---------------------------------------------------------------------------
package slr_pkg;

	// Width of the consumed field on the result channel.
	localparam int unsigned CONSUMED_W = 16;

	// Digits that close a short and a long universal escape.
	localparam logic [3:0] UNI_SHORT_DIGITS = 4'd4;
	localparam logic [3:0] UNI_LONG_DIGITS  = 4'd8;

	// Character codes.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_SEVEN = 8'h37;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_F  = 8'h46;
	localparam logic [7:0] CH_UC_U  = 8'h55;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_B  = 8'h62;
	localparam logic [7:0] CH_LC_E  = 8'h65;
	localparam logic [7:0] CH_LC_F  = 8'h66;
	localparam logic [7:0] CH_LC_N  = 8'h6E;
	localparam logic [7:0] CH_LC_R  = 8'h72;
	localparam logic [7:0] CH_LC_T  = 8'h74;
	localparam logic [7:0] CH_LC_U  = 8'h75;
	localparam logic [7:0] CH_LC_V  = 8'h76;
	localparam logic [7:0] CH_LC_X  = 8'h78;

	// Scanner modes.
	typedef enum logic [2:0] {
		MODE_OPEN   = 3'd0,
		MODE_BODY   = 3'd1,
		MODE_ESC    = 3'd2,
		MODE_OCT    = 3'd3,
		MODE_HEX    = 3'd4,
		MODE_UNI    = 3'd5,
		MODE_IDLE   = 3'd6,
		MODE_SPLICE = 3'd7
	} mode_t;

	// Verdict codes on the result channel.
	typedef enum logic [2:0] {
		V_RUN    = 3'd0,
		V_ACCEPT = 3'd1,
		V_NOTSTR = 3'd2,
		V_BAD    = 3'd3,
		V_IDLE   = 3'd4
	} verdict_t;

	// Scanner state apart from the byte count.
	typedef struct packed {
		mode_t      mode;
		logic [3:0] digit_count;
		logic       wide_escape;
	} scan_state_t;

	// What one byte does: the following state and its verdict.
	typedef struct packed {
		scan_state_t nxt;
		verdict_t    verdict;
	} scan_step_t;

	function automatic logic is_hex(input logic [7:0] c);
		return ((c >= CH_ZERO) && (c <= CH_NINE)) ||
		       ((c >= CH_LC_A) && (c <= CH_LC_F)) ||
		       ((c >= CH_UC_A) && (c <= CH_UC_F));
	endfunction

	function automatic logic is_oct(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_SEVEN);
	endfunction

	function automatic logic is_simple(input logic [7:0] c);
		logic hit;
		hit = 1'b0;
		case (c) inside
			CH_LC_A, CH_LC_B, CH_LC_E, CH_LC_F, CH_LC_V, CH_LC_R, CH_LC_N,
			CH_LC_T, CH_BSL, CH_APOS, CH_QUOTE, CH_QMARK: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

endpackage

@@ hw/rtl/slr_text_if.sv @@
// ---------------------------------------------------------------------------
// slr_text_if: byte channel into the recognizer
// Valid/ready handshake carrying one source byte and the start mark.
// ---------------------------------------------------------------------------
interface slr_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       begin_req;

	modport source (output valid, output text_byte, output begin_req, input ready);
	modport sink (input valid, input text_byte, input begin_req, output ready);
endinterface

@@ hw/rtl/slr_result_if.sv @@
// ---------------------------------------------------------------------------
// slr_result_if: result channel out of the recognizer
// Valid/ready handshake carrying the verdict and the consumed byte count.
// ---------------------------------------------------------------------------
interface slr_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  verdict;
	logic [15:0] consumed;

	modport source (output valid, output verdict, output consumed, input ready);
	modport sink (input valid, input verdict, input consumed, output ready);
endinterface

@@ hw/rtl/string_literal_recognizer_core.sv @@
// ---------------------------------------------------------------------------
// string_literal_recognizer_core: C string literal recognizer
// Checks a string literal one byte per item and reports for every byte
// whether the literal runs on, is accepted or is rejected, or that the scanner is idle, with its length.
//
//   Channel  Role   Payload                       Taken when
//   text     sink   text_byte[7:0], begin_req     text.valid && text.ready
//   result   source verdict[2:0], consumed[15:0]  result.valid && result.ready
//
// The scanner state and byte count update at the edge that accepts the
// byte, and the result appears in the output register on the next cycle.
// One byte per cycle is sustained while the result channel is ready.
// Reset puts the scanner in idle with a zero count and an empty output.
// A held result that is not taken stalls the text channel only while it
// blocks the single output register.
// ---------------------------------------------------------------------------
module string_literal_recognizer_core #(
	parameter int unsigned LEN_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	slr_text_if.sink     text,
	slr_result_if.source result
);

	slr_pkg::scan_state_t state_q;
	logic [LEN_BITS-1:0]  total_q;
	logic [LEN_BITS-1:0]  total_base;
	logic [LEN_BITS-1:0]  total_nx;
	slr_pkg::scan_step_t  step;
	logic                 take;
	logic                 can_load;
	logic [15:0]          consumed_nx;

	assign text.ready = can_load;
	assign take       = text.valid && can_load;

	slr_scan u_scan (
		.cur       (state_q),
		.text_byte (text.text_byte),
		.begin_req (text.begin_req),
		.step      (step)
	);

	// Byte count: cleared by a start mark or a rejection, saturating count
	// on every byte that keeps the literal alive.
	assign total_base = text.begin_req ? '0 : total_q;
	always_comb begin
		total_nx = total_base;
		unique case (step.verdict)
			slr_pkg::V_RUN, slr_pkg::V_ACCEPT: begin
				if (!(&total_base)) total_nx = total_base + {{(LEN_BITS-1){1'b0}}, 1'b1};
			end
			slr_pkg::V_NOTSTR, slr_pkg::V_BAD: total_nx = '0;
			default: total_nx = total_base;
		endcase
	end

	// Fit the count to the result field.
	generate
		if (LEN_BITS > slr_pkg::CONSUMED_W) begin : g_sat
			assign consumed_nx = (|total_nx[LEN_BITS-1:slr_pkg::CONSUMED_W]) ? 16'hFFFF
			                                                                 : total_nx[15:0];
		end else if (LEN_BITS == slr_pkg::CONSUMED_W) begin : g_same
			assign consumed_nx = total_nx[15:0];
		end else begin : g_ext
			assign consumed_nx = {{(slr_pkg::CONSUMED_W - LEN_BITS){1'b0}}, total_nx};
		end
	endgenerate

	// Scanner state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode        <= slr_pkg::MODE_IDLE;
			state_q.digit_count <= 4'd0;
			state_q.wide_escape <= 1'b0;
			total_q             <= '0;
		end else if (take) begin
			state_q <= step.nxt;
			total_q <= total_nx;
		end
	end

	slr_result_reg u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take),
		.verdict  (step.verdict),
		.consumed (consumed_nx),
		.can_load (can_load),
		.result   (result)
	);

	// Every accepted byte yields a result on the next cycle.
	a_byte_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		text.valid && text.ready |=> result.valid)
		else $error("accepted byte produced no result");

	// Rejections report nothing consumed.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && ((result.verdict == slr_pkg::V_NOTSTR) ||
		                 (result.verdict == slr_pkg::V_BAD)) |-> result.consumed == 16'd0)
		else $error("rejected literal reports a nonzero length");

	// A rejection leaves the scanner idle with a cleared count.
	a_reject_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take && ((step.verdict == slr_pkg::V_NOTSTR) || (step.verdict == slr_pkg::V_BAD))
		|=> (state_q.mode == slr_pkg::MODE_IDLE) && (total_q == '0))
		else $error("scanner not idle and cleared after rejection");

endmodule

@@ hw/rtl/slr_scan.sv @@
// ---------------------------------------------------------------------------
// slr_scan: next-state logic of the string literal scanner
// Decides from the current mode and one byte what the mode becomes and
// which verdict the byte earns. Purely combinational.
// ---------------------------------------------------------------------------
module slr_scan (
	input  slr_pkg::scan_state_t cur,
	input  logic [7:0]           text_byte,
	input  logic                 begin_req,
	output slr_pkg::scan_step_t  step
);

	slr_pkg::scan_state_t st0;
	slr_pkg::scan_state_t nxt;
	slr_pkg::mode_t       eff;
	slr_pkg::verdict_t    verdict;
	logic                 is_eol;
	logic                 hex_run_bad;
	logic [3:0]           dc_inc;
	logic [3:0]           uni_limit;

	// A start mark opens a fresh attempt before the byte is looked at.
	always_comb begin
		st0 = cur;
		if (begin_req) begin
			st0.mode        = slr_pkg::MODE_OPEN;
			st0.digit_count = 4'd0;
			st0.wide_escape = 1'b0;
		end
	end

	assign is_eol    = (text_byte == slr_pkg::CH_CR) || (text_byte == slr_pkg::CH_LF);
	assign dc_inc    = st0.digit_count + 4'd1;
	assign uni_limit = st0.wide_escape ? slr_pkg::UNI_LONG_DIGITS
	                                   : slr_pkg::UNI_SHORT_DIGITS;

	// A finished octal or hex run, or a splice, hands its terminating byte to the body
	// handling in the same cycle; a hex run with no digit is malformed.
	always_comb begin
		eff         = st0.mode;
		hex_run_bad = 1'b0;
		unique case (st0.mode)
			slr_pkg::MODE_SPLICE: eff = slr_pkg::MODE_BODY;
			slr_pkg::MODE_OCT: begin
				if (!slr_pkg::is_oct(text_byte)) eff = slr_pkg::MODE_BODY;
			end
			slr_pkg::MODE_HEX: begin
				if (!slr_pkg::is_hex(text_byte)) begin
					eff         = slr_pkg::MODE_BODY;
					hex_run_bad = (st0.digit_count == 4'd0);
				end
			end
			default: eff = st0.mode;
		endcase
	end

	// Byte handling per mode, then the idle return on a final verdict.
	always_comb begin
		nxt     = st0;
		verdict = slr_pkg::V_RUN;
		if (st0.mode == slr_pkg::MODE_IDLE) begin
			verdict = slr_pkg::V_IDLE;
		end else if ((st0.mode == slr_pkg::MODE_ESC) && is_eol) begin
			nxt.mode = (text_byte == slr_pkg::CH_CR) ? slr_pkg::MODE_SPLICE
			                                         : slr_pkg::MODE_BODY;
		end else if ((st0.mode == slr_pkg::MODE_SPLICE) && (text_byte == slr_pkg::CH_LF)) begin
			nxt.mode = slr_pkg::MODE_BODY;
		end else if (is_eol || (text_byte == slr_pkg::CH_NUL)) begin
			verdict = (st0.mode == slr_pkg::MODE_OPEN) ? slr_pkg::V_NOTSTR : slr_pkg::V_BAD;
		end else if (hex_run_bad) begin
			verdict = slr_pkg::V_BAD;
		end else begin
			nxt.mode = eff;
			unique case (eff)
				slr_pkg::MODE_OPEN: begin
					if (text_byte == slr_pkg::CH_QUOTE) nxt.mode = slr_pkg::MODE_BODY;
					else verdict = slr_pkg::V_NOTSTR;
				end
				slr_pkg::MODE_BODY: begin
					if (text_byte == slr_pkg::CH_BSL) nxt.mode = slr_pkg::MODE_ESC;
					else if (text_byte == slr_pkg::CH_QUOTE) verdict = slr_pkg::V_ACCEPT;
				end
				slr_pkg::MODE_ESC: begin
					if (slr_pkg::is_simple(text_byte)) begin
						nxt.mode = slr_pkg::MODE_BODY;
					end else if ((text_byte == slr_pkg::CH_ZERO) ||
					             (text_byte == slr_pkg::CH_ONE)) begin
						nxt.mode = slr_pkg::MODE_OCT;
					end else if (text_byte == slr_pkg::CH_LC_X) begin
						nxt.mode        = slr_pkg::MODE_HEX;
						nxt.digit_count = 4'd0;
					end else if ((text_byte == slr_pkg::CH_LC_U) ||
					             (text_byte == slr_pkg::CH_UC_U)) begin
						nxt.mode        = slr_pkg::MODE_UNI;
						nxt.wide_escape = (text_byte == slr_pkg::CH_UC_U);
						nxt.digit_count = 4'd0;
					end else begin
						verdict = slr_pkg::V_BAD;
					end
				end
				slr_pkg::MODE_OCT: nxt.mode = slr_pkg::MODE_OCT;
				slr_pkg::MODE_HEX: nxt.digit_count = 4'd1;
				slr_pkg::MODE_UNI: begin
					if (!slr_pkg::is_hex(text_byte)) begin
						verdict = slr_pkg::V_BAD;
					end else begin
						nxt.digit_count = dc_inc;
						if (dc_inc >= uni_limit) nxt.mode = slr_pkg::MODE_BODY;
					end
				end
				default: verdict = slr_pkg::V_BAD;
			endcase
		end

		if ((verdict == slr_pkg::V_NOTSTR) || (verdict == slr_pkg::V_BAD)) begin
			nxt.mode        = slr_pkg::MODE_IDLE;
			nxt.digit_count = 4'd0;
			nxt.wide_escape = 1'b0;
		end else if (verdict == slr_pkg::V_ACCEPT) begin
			nxt.mode = slr_pkg::MODE_IDLE;
		end
	end

	assign step.nxt     = nxt;
	assign step.verdict = verdict;

endmodule

@@ hw/rtl/slr_result_reg.sv @@
// ---------------------------------------------------------------------------
// slr_result_reg: output register of the recognizer
// Holds one result item until the sink takes it and tells the front end
// whether a new item can be loaded this cycle.
// ---------------------------------------------------------------------------
module slr_result_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  slr_pkg::verdict_t   verdict,
	input  logic [15:0]         consumed,
	output logic                can_load,
	slr_result_if.source        result
);

	logic                valid_q;
	slr_pkg::verdict_t   verdict_q;
	logic [15:0]         consumed_q;

	// Room when empty or when the held item leaves this cycle.
	assign can_load = !valid_q || result.ready;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (load) begin
			verdict_q  <= verdict;
			consumed_q <= consumed;
		end
	end

	assign result.valid    = valid_q;
	assign result.verdict  = verdict_q;
	assign result.consumed = consumed_q;

endmodule
